### rtl/i2cwfs_pkg.sv
package i2cwfs_pkg;

   // bus event kinds
   localparam logic [1:0] EV_START = 2'd0;
   localparam logic [1:0] EV_BIT   = 2'd1;
   localparam logic [1:0] EV_ACK   = 2'd2;
   localparam logic [1:0] EV_STOP  = 2'd3;

   // control bytes and register defaults
   localparam logic [7:0] ADDR_RESET   = 8'h78;
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;

   // action codes
   localparam logic ACT_COMMAND = 1'b0;
   localparam logic ACT_DATA    = 1'b1;

   // register map
   localparam int          CSR_ADDR_W   = 3;
   localparam logic        REG_DEV_ADDR = 1'b0;

   // frame layout
   localparam int         FRAME_EVENTS = 29;
   localparam logic [1:0] LAST_BYTE    = 2'd2;
   localparam logic [2:0] LAST_BIT     = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   // one frame to send, bytes in bus order
   typedef struct packed {
      logic [7:0] dev_addr;
      logic [7:0] ctrl;
      logic [7:0] payload;
   } frame_type;

   typedef struct packed {
      logic idle;
      logic at_stop;
   } back_status_type;

endpackage

### rtl/i2cwfs_front.sv
module i2cwfs_front (
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   input  logic [7:0]            req_tdata,
   output logic                  req_tready,
   input  logic [7:0]            dev_addr,
   input  logic                  q_full,
   output logic                  q_push,
   output i2cwfs_pkg::frame_type q_wdata
);

   always_comb begin
      req_tready       = !q_full;
      q_push           = req_tvalid && !q_full;
      q_wdata.dev_addr = dev_addr;
      q_wdata.payload  = req_tdata;
      case (req_tuser)
         i2cwfs_pkg::ACT_DATA:    q_wdata.ctrl = i2cwfs_pkg::CTRL_DATA;
         i2cwfs_pkg::ACT_COMMAND: q_wdata.ctrl = i2cwfs_pkg::CTRL_COMMAND;
         default:                 q_wdata.ctrl = i2cwfs_pkg::CTRL_COMMAND;
      endcase
   end

endmodule

### rtl/i2cwfs_queue.sv
module i2cwfs_queue #(
   parameter int DEPTH = i2cwfs_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  i2cwfs_pkg::frame_type             wdata,
   input  logic                              pop,
   output i2cwfs_pkg::frame_type             rdata,
   output logic                              full,
   output logic                              not_empty,
   output logic [$clog2(DEPTH + 1) - 1:0]    count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   i2cwfs_pkg::frame_type mem_ff [DEPTH];
   logic [PTR_W - 1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W - 1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W - 1:0] count_ff, count_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W - 1:0] ptr_next(input logic [PTR_W - 1:0] p);
      logic [PTR_W - 1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      count     = count_ff;
      rdata     = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/i2cwfs_back.sv
module i2cwfs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  i2cwfs_pkg::frame_type       q_rdata,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast,
   output i2cwfs_pkg::back_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BITS = 2'd1;
   localparam logic [1:0] ST_ACK  = 2'd2;
   localparam logic [1:0] ST_STOP = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [23:0] shreg_ff, shreg_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic [1:0]  byte_cnt_ff, byte_cnt_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic        sda_ff, sda_in;
   logic        last_ff, last_in;
   logic        advance, emit;

   always_comb begin
      advance     = !valid_ff || rsp_tready;
      emit        = 1'b0;
      q_pop       = 1'b0;
      state_in    = state_ff;
      shreg_in    = shreg_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      kind_in     = kind_ff;
      sda_in      = sda_ff;
      last_in     = last_ff;
      if (advance) begin
         case (state_ff)
            ST_IDLE: begin
               if (q_not_empty) begin
                  q_pop       = 1'b1;
                  emit        = 1'b1;
                  kind_in     = i2cwfs_pkg::EV_START;
                  sda_in      = 1'b1;
                  last_in     = 1'b0;
                  shreg_in    = q_rdata;
                  bit_cnt_in  = '0;
                  byte_cnt_in = '0;
                  state_in    = ST_BITS;
               end
            end
            ST_BITS: begin
               emit       = 1'b1;
               kind_in    = i2cwfs_pkg::EV_BIT;
               sda_in     = shreg_ff[23];
               last_in    = 1'b0;
               shreg_in   = {shreg_ff[22:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == i2cwfs_pkg::LAST_BIT) begin
                  state_in = ST_ACK;
               end
            end
            ST_ACK: begin
               emit       = 1'b1;
               kind_in    = i2cwfs_pkg::EV_ACK;
               sda_in     = 1'b1;
               last_in    = 1'b0;
               bit_cnt_in = '0;
               if (byte_cnt_ff == i2cwfs_pkg::LAST_BYTE) begin
                  state_in = ST_STOP;
               end else begin
                  byte_cnt_in = byte_cnt_ff + 1'b1;
                  state_in    = ST_BITS;
               end
            end
            ST_STOP: begin
               emit     = 1'b1;
               kind_in  = i2cwfs_pkg::EV_STOP;
               sda_in   = 1'b1;
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      bit_cnt_ff  <= bit_cnt_in;
      byte_cnt_ff <= byte_cnt_in;
      kind_ff     <= kind_in;
      sda_ff      <= sda_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid     = valid_ff;
   assign rsp_tdata      = {7'b0, sda_ff};
   assign rsp_tuser      = kind_ff;
   assign rsp_tlast      = last_ff;
   assign status.idle    = (state_ff == ST_IDLE);
   assign status.at_stop = (state_ff == ST_STOP) && advance;

endmodule

### rtl/i2c_write_frame_serializer_core.sv
// a request is written into the frame queue; the back sequencer then pops it and registers the frame's start event
// one bus event per cycle out of the back sequencer, while rsp_tready does not stall its output stage
// requests are taken back to back while a frame is being sent, until the frame queue fills
// reset: synchronous, active high; empties the queue, idles the sequencer, drops rsp_tvalid
// and sets the device address to 0x78
module i2c_write_frame_serializer_core #(
   parameter int QUEUE_DEPTH = i2cwfs_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] payload
   input  logic                                req_tuser,   // [0] action
   // bus event channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [0] sda_level, [7:1] zero
   output logic [1:0]                          rsp_tuser,   // [1:0] event_kind
   output logic                                rsp_tlast,   // stop condition
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [i2cwfs_pkg::CSR_ADDR_W - 1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // device address register
   logic [7:0] dev_addr_ff, dev_addr_in;
   logic       csr_wr;
   logic       csr_hit;

   // front to queue
   logic                  q_push;
   i2cwfs_pkg::frame_type q_wdata;
   logic                  q_full;

   // queue to back
   logic                  q_pop;
   logic                  q_not_empty;
   i2cwfs_pkg::frame_type q_rdata;
   logic [CNT_W - 1:0]    q_count;

   i2cwfs_pkg::back_status_type back_status;

   // register access, word index is paddr[2]
   always_comb begin
      csr_pready  = 1'b1;
      csr_hit     = (csr_paddr[2] == i2cwfs_pkg::REG_DEV_ADDR);
      csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
      dev_addr_in = (csr_wr && csr_hit) ? csr_pwdata[7:0] : dev_addr_ff;
      csr_prdata  = csr_hit ? {24'b0, dev_addr_ff} : 32'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cwfs_pkg::ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   // front: classify the request and build the three frame bytes
   i2cwfs_front u_front (
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .dev_addr   (dev_addr_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // short frame queue decoupling front from back
   i2cwfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wdata     (q_wdata),
      .pop       (q_pop),
      .rdata     (q_rdata),
      .full      (q_full),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // back: start, 3 x (8 bits + ack), stop, into a registered output stage
   i2cwfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rdata     (q_rdata),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .status      (back_status)
   );

`ifndef SYNTHESIS
   // a taken request is queued on the next cycle
   a_req_queued: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> q_count != '0)
      else $error("request taken but queue empty");

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // stop step of the sequencer shows up as the last event
   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      back_status.at_stop |=> rsp_tvalid && rsp_tlast && rsp_tuser == i2cwfs_pkg::EV_STOP)
      else $error("stop step did not present last event");

   // a frame only starts when the sequencer is idle and a frame is queued
   a_start_from_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> back_status.idle && q_not_empty)
      else $error("frame popped while sequencer busy");
`endif

endmodule
